// ----- design/vqcs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vqcs_pkg: shared types and constants of the cepstrum-to-spectrum decoder
// Field widths, item kinds, default sizes and the structs passed between the
// point datapath, the result packer and the sequencer.
// ----------------------------------------------------------------------------
package vqcs_pkg;

  // default sizes
  localparam int VQCS_ENTRIES    = 256;
  localparam int VQCS_COEFFS     = 13;
  localparam int VQCS_POINTS     = 85;
  localparam int VQCS_PER_RESULT = 5;

  // fixed field widths
  localparam int ENTRY_W = 8;
  localparam int CIDX_W  = 4;
  localparam int COEF_W  = 16;
  localparam int CODE_W  = 8;
  localparam int PBASE_W = 7;
  localparam int PT_W    = 20;
  localparam int COS_W   = 16;
  localparam int PROD_W  = 32;
  localparam int SLOTS   = 5;

  // item kinds
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_DECODE = 1'b1;

  // control from the sequencer to the point datapath
  typedef struct packed {
    logic clear;
    logic issue;
    logic last;
  } dot_ctl_t;

  // one finished spectrum point
  typedef struct packed {
    logic                   valid;
    logic                   last;
    logic signed [PT_W-1:0] value;
  } pt_t;

endpackage
`default_nettype wire

// ----- design/vqcs_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vqcs_in_if: input channel
// Valid/ready channel carrying codebook writes and decode requests.
// ----------------------------------------------------------------------------
interface vqcs_in_if import vqcs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [ENTRY_W-1:0]       entry_index;
  logic [CIDX_W-1:0]        coeff_index;
  logic signed [COEF_W-1:0] coeff_value;
  logic [CODE_W-1:0]        code;

  modport source (output valid, kind, entry_index, coeff_index, coeff_value, code,
                  input ready);
  modport sink (input valid, kind, entry_index, coeff_index, coeff_value, code,
                output ready);
endinterface
`default_nettype wire

// ----- design/vqcs_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vqcs_out_if: result channel
// Valid/ready channel carrying five spectrum points and running extremes.
// ----------------------------------------------------------------------------
interface vqcs_out_if import vqcs_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [PBASE_W-1:0]     point_base;
  logic signed [PT_W-1:0] point_a;
  logic signed [PT_W-1:0] point_b;
  logic signed [PT_W-1:0] point_c;
  logic signed [PT_W-1:0] point_d;
  logic signed [PT_W-1:0] point_e;
  logic                   last_of_frame;
  logic signed [PT_W-1:0] running_min;
  logic signed [PT_W-1:0] running_max;

  modport source (output valid, point_base, point_a, point_b, point_c, point_d, point_e,
                  last_of_frame, running_min, running_max,
                  input ready);
  modport sink (input valid, point_base, point_a, point_b, point_c, point_d, point_e,
                last_of_frame, running_min, running_max,
                output ready);
endinterface
`default_nettype wire

// ----- design/vqcs_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vqcs_ram: generic single-port RAM
// One address per cycle, write or read, read data registered.
// ----------------------------------------------------------------------------
module vqcs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// ----- design/vqcs_dot.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vqcs_dot: spectrum point datapath
// One point per cycle while adv is high: phase fold, cosine lookup, one
// multiplier per coefficient, registered adder tree, rounding and saturation.
// ----------------------------------------------------------------------------
module vqcs_dot import vqcs_pkg::*; #(
  parameter int COEFFS_PER_ENTRY = VQCS_COEFFS,
  parameter int SPECTRUM_POINTS  = VQCS_POINTS
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     adv,
  input  wire dot_ctl_t                 ctl,
  input  wire logic signed [COEF_W-1:0] coef [COEFFS_PER_ENTRY],
  output pt_t                           pt
);

  localparam int N2     = 2 * SPECTRUM_POINTS;
  localparam int PH_W   = $clog2(N2);
  localparam int TAB_N  = SPECTRUM_POINTS / 2 + 1;
  localparam int TAB_W  = $clog2(TAB_N);
  localparam int NG     = (COEFFS_PER_ENTRY + 3) / 4;
  localparam int PART_W = PROD_W + 2;
  localparam int ACC_W  = PART_W + $clog2(NG) + 1;
  localparam int NSTAGE = 6;

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((1 << (PT_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(1 << (PT_W - 1));

  // cos(pi*m/SPECTRUM_POINTS) in Q1.14 for 0 <= m <= SPECTRUM_POINTS/2,
  // evaluated at elaboration only
  function automatic logic signed [COS_W-1:0] cos_q14(int unsigned m);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    x    = (64'd3373259426 * 64'(m) + 64'(SPECTRUM_POINTS / 2)) / SPECTRUM_POINTS;
    x2   = (x * x + (64'd1 << 29)) >> 30;
    term = 64'd1 << 30;
    sum  = longint'(term);
    term = ((term * x2) >> 30) / 2;   sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 12;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 30;  sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 56;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 90;  sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 132; sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 182; sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 240; sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 306; sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 380; sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 462; sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 552; sum = sum + longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    sum = (sum + 64'sd32768) >>> 16;
    return COS_W'(sum);
  endfunction

  logic signed [COS_W-1:0]  cos_tab [TAB_N];
  logic [TAB_W-1:0]         fidx_r  [COEFFS_PER_ENTRY];
  logic                     fneg_r  [COEFFS_PER_ENTRY];
  logic signed [COS_W-1:0]  cos_r   [COEFFS_PER_ENTRY];
  logic signed [PROD_W-1:0] prod_r  [COEFFS_PER_ENTRY];
  logic signed [PART_W-1:0] part_nxt [NG];
  logic signed [PART_W-1:0] part_r   [NG];
  logic signed [ACC_W-1:0]  sum_nxt;
  logic signed [ACC_W-1:0]  sum_r;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [PT_W-1:0]   pt_nxt;
  logic signed [PT_W-1:0]   pt_r;
  logic [NSTAGE-1:0]        vld_r;
  logic [NSTAGE-1:0]        lst_r;

  for (genvar t = 0; t < TAB_N; t++) begin : g_tab
    localparam logic signed [COS_W-1:0] CV = cos_q14(t);
    assign cos_tab[t] = CV;
  end

  for (genvar i = 0; i < COEFFS_PER_ENTRY; i++) begin : g_lane
    localparam int STEP = i % N2;
    logic [PH_W-1:0] ph_r;
    logic [PH_W-1:0] ph_nxt;
    logic [PH_W:0]   ph_sum;
    logic [PH_W:0]   ph_ext;
    logic [PH_W:0]   fa;
    logic [PH_W:0]   fb;
    logic            fneg;

    always_comb begin
      ph_sum = {1'b0, ph_r} + (PH_W + 1)'(STEP);
      if (ph_sum >= (PH_W + 1)'(N2)) begin
        ph_nxt = PH_W'(ph_sum - (PH_W + 1)'(N2));
      end else begin
        ph_nxt = PH_W'(ph_sum);
      end
      // fold the phase into the first quarter wave
      ph_ext = {1'b0, ph_r};
      fa     = (ph_ext > (PH_W + 1)'(SPECTRUM_POINTS)) ? (PH_W + 1)'(N2) - ph_ext : ph_ext;
      fneg   = {fa, 1'b0} > (PH_W + 2)'(SPECTRUM_POINTS);
      fb     = fneg ? (PH_W + 1)'(SPECTRUM_POINTS) - fa : fa;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ph_r <= '0;
      end else if (ctl.clear) begin
        ph_r <= '0;
      end else if (adv && ctl.issue) begin
        ph_r <= ph_nxt;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        fidx_r[i] <= TAB_W'(fb);
        fneg_r[i] <= fneg;
        cos_r[i]  <= fneg_r[i] ? -cos_tab[fidx_r[i]] : cos_tab[fidx_r[i]];
        prod_r[i] <= coef[i] * cos_r[i];
      end
    end
  end

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      part_nxt[g] = '0;
      for (int k = 0; k < 4; k++) begin
        if (g * 4 + k < COEFFS_PER_ENTRY) begin
          part_nxt[g] = part_nxt[g] + PART_W'(prod_r[g * 4 + k]);
        end
      end
    end
    sum_nxt = '0;
    for (int g = 0; g < NG; g++) begin
      sum_nxt = sum_nxt + ACC_W'(part_r[g]);
    end
    // round half up, dropping the 14 cosine fraction bits, then saturate
    rnd = (sum_r + ACC_W'(8192)) >>> 14;
    if (rnd > SAT_HI) begin
      pt_nxt = PT_W'(SAT_HI);
    end else if (rnd < SAT_LO) begin
      pt_nxt = PT_W'(SAT_LO);
    end else begin
      pt_nxt = PT_W'(rnd);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      part_r <= part_nxt;
      sum_r  <= sum_nxt;
      pt_r   <= pt_nxt;
      lst_r  <= {lst_r[NSTAGE-2:0], ctl.last};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTAGE-2:0], ctl.issue};
    end
  end

  assign pt.valid = vld_r[NSTAGE-1];
  assign pt.last  = lst_r[NSTAGE-1];
  assign pt.value = pt_r;

endmodule
`default_nettype wire

// ----- design/vqcs_pack.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vqcs_pack: result packer
// Gathers points into groups, tracks running extremes and holds the result
// register of the output channel. Stalls the datapath when a group waits.
// ----------------------------------------------------------------------------
module vqcs_pack import vqcs_pkg::*; #(
  parameter int SPECTRUM_POINTS   = VQCS_POINTS,
  parameter int POINTS_PER_RESULT = VQCS_PER_RESULT
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire pt_t    pt,
  output logic        adv,
  output logic        frame_done,
  vqcs_out_if.source  out_ch
);

  localparam int BASE_W = $clog2(SPECTRUM_POINTS);
  localparam int SLOT_W = $clog2(SLOTS);

  logic [SLOT_W-1:0]      slot_r;
  logic signed [PT_W-1:0] pts_r [SLOTS];
  logic                   grp_done_r;
  logic                   grp_last_r;
  logic [BASE_W-1:0]      base_r;
  logic                   any_r;
  logic signed [PT_W-1:0] min_r;
  logic signed [PT_W-1:0] max_r;
  logic                   out_valid_r;
  logic [PBASE_W-1:0]     out_base_r;
  logic signed [PT_W-1:0] out_pts_r [SLOTS];
  logic                   out_last_r;
  logic signed [PT_W-1:0] out_min_r;
  logic signed [PT_W-1:0] out_max_r;
  logic                   take;
  logic                   load;
  logic                   grp_end;

  assign load       = grp_done_r && (!out_valid_r || out_ch.ready);
  assign adv        = !grp_done_r || load;
  assign take       = pt.valid && adv;
  assign grp_end    = (slot_r == SLOT_W'(POINTS_PER_RESULT - 1)) || pt.last;
  assign frame_done = load && grp_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= '0;
      grp_done_r  <= 1'b0;
      base_r      <= '0;
      any_r       <= 1'b0;
      min_r       <= '0;
      max_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        slot_r <= grp_end ? '0 : slot_r + 1'b1;
        if (!any_r) begin
          min_r <= pt.value;
          max_r <= pt.value;
        end else begin
          if (pt.value < min_r) min_r <= pt.value;
          if (pt.value > max_r) max_r <= pt.value;
        end
        any_r <= 1'b1;
      end
      grp_done_r <= (grp_done_r && !load) || (take && grp_end);
      if (load) begin
        base_r <= grp_last_r ? '0 : base_r + BASE_W'(POINTS_PER_RESULT);
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // open a group by clearing the unused slots
  always_ff @(posedge clk) begin
    if (take) begin
      if (slot_r == '0) begin
        for (int k = 1; k < SLOTS; k++) begin
          pts_r[k] <= '0;
        end
      end
      pts_r[slot_r] <= pt.value;
      grp_last_r    <= pt.last;
    end
    if (load) begin
      out_base_r <= PBASE_W'(base_r);
      out_pts_r  <= pts_r;
      out_last_r <= grp_last_r;
      out_min_r  <= min_r;
      out_max_r  <= max_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.point_base    = out_base_r;
  assign out_ch.point_a       = out_pts_r[0];
  assign out_ch.point_b       = out_pts_r[1];
  assign out_ch.point_c       = out_pts_r[2];
  assign out_ch.point_d       = out_pts_r[3];
  assign out_ch.point_e       = out_pts_r[4];
  assign out_ch.last_of_frame = out_last_r;
  assign out_ch.running_min   = out_min_r;
  assign out_ch.running_max   = out_max_r;

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    any_r |-> (min_r <= max_r))
    else $error("running minimum above running maximum");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r < SLOT_W'(POINTS_PER_RESULT))
    else $error("collector slot beyond group size");

  a_base_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (load && grp_last_r) |=> (base_r == '0))
    else $error("point base not rewound after last group");

endmodule
`default_nettype wire

// ----- design/vq_cepstrum_to_spectrum.sv -----
`default_nettype none
// Writes: one codebook write per cycle while idle.
// Decodes: the coefficients of the entry are fetched one per cycle, then the
//   points are issued one per cycle while the packer does not stall the datapath;
//   no new write or decode is accepted until the last result of a decode sits
//   in the output register.
// Reset: control, extremes and counters clear; the codebook is undefined.
// ----------------------------------------------------------------------------
// vq_cepstrum_to_spectrum: vector quantizer decode with inverse cosine transform
// Holds a codebook of cepstral vectors in RAM and, for each decoded code,
// streams the spectrum points in groups with running minimum and maximum.
// ----------------------------------------------------------------------------
module vq_cepstrum_to_spectrum import vqcs_pkg::*; #(
  parameter int CODEBOOK_ENTRIES  = VQCS_ENTRIES,
  parameter int COEFFS_PER_ENTRY  = VQCS_COEFFS,
  parameter int SPECTRUM_POINTS   = VQCS_POINTS,
  parameter int POINTS_PER_RESULT = VQCS_PER_RESULT
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  vqcs_in_if.sink    in_ch,
  vqcs_out_if.source out_ch
);

  localparam int DEPTH  = CODEBOOK_ENTRIES * COEFFS_PER_ENTRY;
  localparam int AW     = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(COEFFS_PER_ENTRY + 1);
  localparam int CI_W   = (COEFFS_PER_ENTRY > 1) ? $clog2(COEFFS_PER_ENTRY) : 1;
  localparam int PCNT_W = $clog2(SPECTRUM_POINTS);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_LOAD  = 4'b0010,
    ST_RUN   = 4'b0100,
    ST_DRAIN = 4'b1000
  } st_t;

  st_t                      st_r;
  st_t                      st_nxt;
  logic [AW-1:0]            base_addr_r;
  logic [CNT_W-1:0]         iss_cnt_r;
  logic                     rd_pend_r;
  logic [CI_W-1:0]          rd_slot_r;
  logic [PCNT_W-1:0]        pt_cnt_r;
  logic signed [COEF_W-1:0] coef_r [COEFFS_PER_ENTRY];
  logic                     in_fire;
  logic                     wr_ok;
  logic                     code_ok;
  logic                     issuing;
  logic                     ram_we;
  logic [AW-1:0]            ram_addr;
  logic [AW-1:0]            wr_addr;
  logic [COEF_W-1:0]        ram_rdata;
  logic                     adv;
  logic                     frame_done;
  logic                     load_done;
  logic                     pt_last;
  dot_ctl_t                 dot_ctl;
  pt_t                      pt;

  // accept only in idle; a waiting result is held by the packer
  assign in_ch.ready = (st_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // drop writes and codes that fall outside the codebook
  assign wr_ok   = (in_ch.kind == KIND_WRITE)
                && ({1'b0, in_ch.entry_index} < (ENTRY_W + 1)'(CODEBOOK_ENTRIES))
                && ({1'b0, in_ch.coeff_index} < (CIDX_W + 1)'(COEFFS_PER_ENTRY));
  assign code_ok = ({1'b0, in_ch.code} < (CODE_W + 1)'(CODEBOOK_ENTRIES));

  assign wr_addr   = AW'(int'(in_ch.entry_index) * COEFFS_PER_ENTRY
                         + int'(in_ch.coeff_index));
  assign issuing   = (st_r == ST_LOAD) && (iss_cnt_r < CNT_W'(COEFFS_PER_ENTRY));
  assign ram_we    = in_fire && wr_ok;
  assign ram_addr  = (st_r == ST_LOAD) ? base_addr_r + AW'(iss_cnt_r) : wr_addr;
  assign load_done = rd_pend_r && (rd_slot_r == CI_W'(COEFFS_PER_ENTRY - 1));
  assign pt_last   = (pt_cnt_r == PCNT_W'(SPECTRUM_POINTS - 1));

  vqcs_ram #(
    .WIDTH (COEF_W),
    .DEPTH (DEPTH)
  ) u_codebook (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_ch.coeff_value),
    .rdata (ram_rdata)
  );

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (in_fire && (in_ch.kind == KIND_DECODE) && code_ok) st_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (load_done) st_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (adv && pt_last) st_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (frame_done) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      iss_cnt_r <= '0;
      rd_pend_r <= 1'b0;
      pt_cnt_r  <= '0;
    end else begin
      st_r      <= st_nxt;
      rd_pend_r <= issuing;
      if (st_r == ST_IDLE) begin
        iss_cnt_r <= '0;
      end else if (issuing) begin
        iss_cnt_r <= iss_cnt_r + 1'b1;
      end
      if (st_r != ST_RUN) begin
        pt_cnt_r <= '0;
      end else if (adv) begin
        pt_cnt_r <= pt_cnt_r + 1'b1;
      end
    end
  end

  // fetch pipeline: address, then capture into the coefficient lane
  always_ff @(posedge clk) begin
    if (in_fire) begin
      base_addr_r <= AW'(int'(in_ch.code) * COEFFS_PER_ENTRY);
    end
    rd_slot_r <= CI_W'(iss_cnt_r);
    if (rd_pend_r) begin
      coef_r[rd_slot_r] <= $signed(ram_rdata);
    end
  end

  // phases stay at zero until the first point of a frame is issued
  assign dot_ctl.clear = (st_r != ST_RUN);
  assign dot_ctl.issue = (st_r == ST_RUN);
  assign dot_ctl.last  = pt_last;

  vqcs_dot #(
    .COEFFS_PER_ENTRY (COEFFS_PER_ENTRY),
    .SPECTRUM_POINTS  (SPECTRUM_POINTS)
  ) u_dot (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .ctl   (dot_ctl),
    .coef  (coef_r),
    .pt    (pt)
  );

  vqcs_pack #(
    .SPECTRUM_POINTS   (SPECTRUM_POINTS),
    .POINTS_PER_RESULT (POINTS_PER_RESULT)
  ) u_pack (
    .clk        (clk),
    .rst_n      (rst_n),
    .pt         (pt),
    .adv        (adv),
    .frame_done (frame_done),
    .out_ch     (out_ch)
  );

  a_decode_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_ch.kind == KIND_DECODE) && code_ok) |=> (st_r == ST_LOAD))
    else $error("decode transaction did not start a coefficient fetch");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    ((st_r == ST_RUN) && !adv) |=> $stable(pt_cnt_r))
    else $error("point issued while the datapath was stalled");

  a_done_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    frame_done |-> (st_r == ST_DRAIN))
    else $error("frame completed outside the drain phase");

endmodule
`default_nettype wire
